// File: hw/rtl/sgan_pkg.sv
// Shared types and constants for the normalized speaker gain block.
// Holds the queue item, the item classes, register indexes and the
// root table for the fractional power step. No dependencies.
package sgan_pkg;

    localparam int MAX_SPEAKERS_DEF = 32;
    localparam int FIFO_DEPTH       = 2;
    localparam int MAG_W            = 14;
    localparam int SUM_W            = 40;
    localparam int ROOT_W           = 31;

    localparam logic signed [17:0] PI_Q12     = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
    localparam logic [15:0]        ONE_Q15    = 16'h8000;

    typedef enum logic [1:0] {
        CFG_AZIMUTH  = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_EXPONENT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        K_CENTER  = 3'b001,
        K_OUTSIDE = 3'b010,
        K_RATIO   = 3'b100
    } t_kind;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        t_kind            kind;
        logic             last;
    } t_item;

    typedef logic [15:0][29:0] t_root_tab;

    // r_0 = 2^29, r_i = isqrt(r_(i-1) << 30): Q30 values of 2^-(2^-i)
    function automatic t_root_tab root_table();
        t_root_tab   tab;
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] q;
        logic [63:0] b;
        int          i;
        int          j;
        r = 64'd1 << 29;
        for (i = 0; i < 16; i++) begin
            v = r << 30;
            q = 64'd0;
            b = 64'h4000_0000_0000_0000;
            for (j = 0; j < 32; j++) begin
                if (v >= q + b) begin
                    v = v - (q + b);
                    q = (q >> 1) + b;
                end else begin
                    q = q >> 1;
                end
                b = b >> 2;
            end
            r = q;
            tab[i] = r[29:0];
        end
        return tab;
    endfunction

endpackage

// File: hw/rtl/sgan_front.sv
// Front end: wraps the speaker angle against the source azimuth and
// classifies the speaker as centered, outside the source width, or ratio.
// Depends on sgan_pkg.
module sgan_front (
    input  logic signed [15:0] i_speaker_angle,
    input  logic               i_last_speaker,
    input  logic [14:0]        i_azimuth,
    input  logic [15:0]        i_width,
    output sgan_pkg::t_item    o_item
);
    import sgan_pkg::*;

    logic signed [17:0] d0, d1, d2, d2b, d3, dabs;
    logic [15:0]        w_eff;
    logic [MAG_W-1:0]   mag;

    always_comb begin
        d0   = $signed({{2{i_speaker_angle[15]}}, i_speaker_angle}) -
               $signed({3'b000, i_azimuth});
        // the most negative difference needs three turns to reach -pi..pi
        d1   = (d0 < -PI_Q12) ? d0 + TWO_PI_Q12 : d0;
        d2   = (d1 < -PI_Q12) ? d1 + TWO_PI_Q12 : d1;
        d2b  = (d2 < -PI_Q12) ? d2 + TWO_PI_Q12 : d2;
        d3   = (d2b > PI_Q12) ? d2b - TWO_PI_Q12 : d2b;
        dabs = (d3 < 0) ? -d3 : d3;
        mag  = dabs[MAG_W-1:0];
        w_eff = (i_width == 16'd0) ? 16'd1 : i_width;

        o_item.mag  = mag;
        o_item.last = i_last_speaker;
        if (mag == '0) begin
            o_item.kind = K_CENTER;
        end else if ({1'b0, mag, 1'b0} >= w_eff) begin
            o_item.kind = K_OUTSIDE;
        end else begin
            o_item.kind = K_RATIO;
        end
    end

endmodule

// File: hw/rtl/sgan_fifo.sv
// Short queue between the front end and the gain engine.
// Depends on sgan_pkg for the item type and depth.
module sgan_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sgan_pkg::t_item i_data,
    output logic            o_full,
    input  logic            i_pop,
    output sgan_pkg::t_item o_data,
    output logic            o_empty
);
    import sgan_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/sgan_back.sv
// Gain engine: divider, log and power iterations, gain store, square sum,
// root of the sum and the normalizing walk over the store.
// Depends on sgan_pkg.
module sgan_back #(
    parameter int MAX_SPEAKERS = sgan_pkg::MAX_SPEAKERS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sgan_pkg::t_item i_item,
    input  logic            i_empty,
    output logic            o_pop,
    input  logic [15:0]     i_width,
    input  logic [14:0]     i_exponent,
    output logic [15:0]     o_gain,
    output logic            o_last_gain,
    output logic            o_valid,
    input  logic            i_ready
);
    import sgan_pkg::*;

    localparam int CNT_W = $clog2(MAX_SPEAKERS + 1);
    localparam int IDX_W = $clog2(MAX_SPEAKERS);
    localparam t_root_tab ROOT_TAB = root_table();

    typedef enum logic [12:0] {
        S_IDLE  = 13'h0001,
        S_DIV   = 13'h0002,
        S_NORM  = 13'h0004,
        S_LOG   = 13'h0008,
        S_MUL   = 13'h0010,
        S_EXP   = 13'h0020,
        S_PEND  = 13'h0040,
        S_STORE = 13'h0080,
        S_FIN   = 13'h0100,
        S_SQRT  = 13'h0200,
        S_E_RD  = 13'h0400,
        S_E_LD  = 13'h0800,
        S_E_DIV = 13'h1000
    } t_state;

    t_state             r_state;
    logic               r_out_valid;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic               r_last;
    logic [15:0]        r_rem;
    logic [16:0]        r_quo;
    logic [16:0]        r_y;
    logic [4:0]         r_k;
    logic [15:0]        r_frac;
    logic [4:0]         r_cnt;
    logic [24:0]        r_e;
    logic [30:0]        r_p;
    logic [45:0]        r_acc;
    logic               r_phase;
    logic [15:0]        r_g;
    logic [59:0]        r_v, r_r, r_b;
    logic [ROOT_W-1:0]  r_root;
    logic [IDX_W-1:0]   r_idx;
    logic [15:0]        r_rd;
    logic [16:0]        r_num;
    logic [31:0]        r_drem;
    logic [16:0]        r_dq;
    logic [15:0]        r_out_gain;
    logic               r_out_last;
    logic [15:0]        r_mem [MAX_SPEAKERS];

    // datapath helpers
    logic [15:0] w_eff;
    logic [15:0] x2;
    logic [16:0] div_sh;
    logic        div_ge;
    logic [16:0] div_q;
    logic [33:0] sq;
    logic [17:0] sq_t;
    logic [20:0] log_l;
    logic [36:0] e_prod;
    logic        e_bit;
    logic [29:0] root_c;
    logic [45:0] p_lo, p_hi;
    logic [60:0] p_full;
    logic [8:0]  ip;
    logic [30:0] p_sh;
    logic [31:0] p_rnd;
    logic [16:0] p15;
    logic [15:0] g_pow;
    logic [31:0] g_sq;
    logic [59:0] sq_t_rb;
    logic        sq_ge;
    logic [59:0] sq_r_n;
    logic [40:0] n_num;
    logic [31:0] ed_sh;
    logic        ed_ge;
    logic [16:0] ed_q;
    logic        in_room;

    always_comb begin
        w_eff   = (i_width == 16'd0) ? 16'd1 : i_width;
        x2      = {((i_exponent == 15'd0) ? 15'd1 : i_exponent), 1'b0};
        in_room = (r_count < CNT_W'(MAX_SPEAKERS));

        div_sh = {r_rem, 1'b0};
        div_ge = (div_sh >= {1'b0, w_eff});
        div_q  = {r_quo[15:0], div_ge};

        sq   = r_y * r_y;
        sq_t = sq[33:16];

        log_l  = {r_k, 16'd0} - {5'd0, r_frac};
        e_prod = log_l * x2;

        e_bit  = r_e[4'd15 - r_cnt[3:0]];
        root_c = ROOT_TAB[r_cnt[3:0]];
        p_lo   = r_p * root_c[14:0];
        p_hi   = r_p * root_c[29:15];
        p_full = {15'd0, r_acc} + {p_hi, 15'd0};

        ip    = r_e[24:16];
        p_sh  = (ip >= 9'd31) ? 31'd0 : (r_p >> ip[4:0]);
        p_rnd = {1'b0, p_sh} + 32'h0000_4000;
        p15   = p_rnd[31:15];
        g_pow = (p15 >= {1'b0, ONE_Q15}) ? 16'd0 : 16'(({1'b0, ONE_Q15}) - p15);

        g_sq = r_g * r_g;

        sq_t_rb = r_r + r_b;
        sq_ge   = (r_v >= sq_t_rb);
        sq_r_n  = sq_ge ? ((r_r >> 1) + r_b) : (r_r >> 1);

        n_num = {r_rd, 25'd0} + {10'd0, (r_root >> 1)};
        ed_sh = {r_drem[30:0], r_num[16]};
        ed_ge = (ed_sh >= {1'b0, r_root});
        ed_q  = {r_dq[15:0], ed_ge};
    end

    assign o_pop       = (r_state == S_IDLE) && !i_empty && !r_out_valid;
    assign o_valid     = r_out_valid;
    assign o_gain      = r_out_gain;
    assign o_last_gain = r_out_last;

    // gain store, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE) begin
            r_mem[r_count[IDX_W-1:0]] <= r_g;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_last <= i_item.last;
                        if (in_room) begin
                            case (i_item.kind)
                                K_CENTER: begin
                                    r_g     <= ONE_Q15;
                                    r_state <= S_STORE;
                                end
                                K_OUTSIDE: begin
                                    r_g     <= 16'd0;
                                    r_state <= S_STORE;
                                end
                                default: begin
                                    r_rem   <= {2'b00, i_item.mag};
                                    r_quo   <= '0;
                                    r_cnt   <= '0;
                                    r_state <= S_DIV;
                                end
                            endcase
                        end else if (i_item.last) begin
                            // dropped speaker still ends the run
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? 16'(div_sh - {1'b0, w_eff}) : div_sh[15:0];
                    r_quo <= div_q;
                    if (r_cnt == 5'd16) begin
                        r_y     <= {1'b0, div_q[15:0]};
                        r_k     <= '0;
                        r_state <= S_NORM;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_NORM: begin
                    if (r_y[16]) begin
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= S_LOG;
                    end else begin
                        r_y <= {r_y[15:0], 1'b0};
                        r_k <= r_k + 1'b1;
                    end
                end
                S_LOG: begin
                    r_y    <= sq_t[17] ? sq_t[17:1] : sq_t[16:0];
                    r_frac <= {r_frac[14:0], sq_t[17]};
                    if (r_cnt == 5'd15) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: begin
                    r_e     <= e_prod[36:12];
                    r_p     <= 31'd1 << 30;
                    r_cnt   <= '0;
                    r_phase <= 1'b0;
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    if (e_bit && !r_phase) begin
                        r_acc   <= p_lo;
                        r_phase <= 1'b1;
                    end else begin
                        if (e_bit) begin
                            r_p <= p_full[60:30];
                        end
                        r_phase <= 1'b0;
                        if (r_cnt == 5'd15) begin
                            r_state <= S_PEND;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_PEND: begin
                    r_g     <= g_pow;
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    r_sum   <= r_sum + SUM_W'(g_sq);
                    r_count <= r_count + 1'b1;
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_idx <= '0;
                    if (r_sum == '0) begin
                        r_root  <= '0;
                        r_state <= S_E_RD;
                    end else begin
                        r_v     <= {r_sum, 20'd0};
                        r_r     <= '0;
                        r_b     <= 60'd1 << 58;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_v <= r_v - sq_t_rb;
                    end
                    r_r <= sq_r_n;
                    r_b <= r_b >> 2;
                    if (r_cnt == 5'd29) begin
                        r_root  <= sq_r_n[ROOT_W-1:0];
                        r_state <= S_E_RD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_E_RD: begin
                    r_state <= S_E_LD;
                end
                S_E_LD: begin
                    r_out_last <= (CNT_W'(r_idx) + 1'b1 == r_count);
                    if (r_root == '0) begin
                        r_out_gain  <= r_rd;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_drem  <= {8'd0, n_num[40:17]};
                        r_num   <= n_num[16:0];
                        r_dq    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_E_DIV;
                    end
                end
                S_E_DIV: begin
                    r_drem <= ed_ge ? (ed_sh - {1'b0, r_root}) : ed_sh;
                    r_num  <= {r_num[15:0], 1'b0};
                    r_dq   <= ed_q;
                    if (r_cnt == 5'd16) begin
                        r_out_gain  <= (ed_q > {1'b0, ONE_Q15}) ? ONE_Q15 : ed_q[15:0];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // hold the result until taken, then advance the walk or close the run
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
                if (r_out_last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_E_RD;
                end
            end
        end
    end

endmodule

// File: hw/rtl/speaker_gain_array_normalized_core.sv
// Power-normalized amplitude panning over a speaker layout.
// Input channel (i_valid/o_ready): one speaker angle per transaction, signed
// Q4.12 radians, with i_last_speaker on the final speaker of the layout.
// Output channel (o_valid/i_ready): after the last speaker, one gain per
// stored speaker (unsigned Q1.15), o_last_gain on the final one.
// Configuration: i_cfg_we writes register i_cfg_idx (0 azimuth, 1 width,
// 2 exponent) with i_cfg_data at once; write only while idle.
// Per speaker: the store write alone when centered or outside the source width,
// otherwise 17 divider steps, up to 16 normalize shifts, 16 log squarings,
// one multiply and 16 to 32 power steps on the split Q30 multiplier.
// A two-entry queue keeps taking speakers meanwhile.
// At the last speaker, the square root of the sum is taken, then each gain
// needs a store read and, for a nonzero sum, 17 divider steps before it is shown.
// A stalled receiver holds the current gain and pauses the walk; the front
// queue still fills. Reset clears the run and loads the register defaults.
module speaker_gain_array_normalized_core #(
    parameter int MAX_SPEAKERS = sgan_pkg::MAX_SPEAKERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_speaker_angle,
    input  logic               i_last_speaker,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_gain,
    output logic               o_last_gain,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import sgan_pkg::*;

    logic [14:0] r_azimuth;
    logic [15:0] r_width;
    logic [14:0] r_exponent;

    t_item front_item, queue_item;
    logic  queue_full, queue_empty, queue_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_azimuth  <= 15'd0;
            r_width    <= 16'd25736;
            r_exponent <= 15'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AZIMUTH:  r_azimuth  <= i_cfg_data[14:0];
                CFG_WIDTH:    r_width    <= i_cfg_data;
                CFG_EXPONENT: r_exponent <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    assign o_ready = !queue_full;

    sgan_front u_front (
        .i_speaker_angle (i_speaker_angle),
        .i_last_speaker  (i_last_speaker),
        .i_azimuth       (r_azimuth),
        .i_width         (r_width),
        .o_item          (front_item)
    );

    sgan_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !queue_full),
        .i_data  (front_item),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_data  (queue_item),
        .o_empty (queue_empty)
    );

    sgan_back #(
        .MAX_SPEAKERS (MAX_SPEAKERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (queue_item),
        .i_empty     (queue_empty),
        .o_pop       (queue_pop),
        .i_width     (r_width),
        .i_exponent  (r_exponent),
        .o_gain      (o_gain),
        .o_last_gain (o_last_gain),
        .o_valid     (o_valid),
        .i_ready     (i_ready)
    );

endmodule

// File: verif/speaker_gain_array_normalized_tb.sv
// Self-checking testbench for speaker_gain_array_normalized_core.
// Holds a gain predictor in a scoreboard class plus handshake driving tasks.
// Depends on sgan_pkg and the core RTL.
class gain_scoreboard;
    typedef struct {
        bit [15:0] gain;
        bit        last;
    } gain_exp_t;

    bit [15:0]         store[32];
    longint unsigned   sq_sum;
    int                count;
    int                azimuth;
    int                width;
    int                exponent;
    longint unsigned   roots[17];
    gain_exp_t         pending[$];
    int                errors;
    int                checked;
    int                accepted;

    function new();
        roots[0] = 64'd1 << 29;
        for (int i = 1; i <= 16; i++) begin
            roots[i] = isqrt(roots[i-1] << 30);
        end
        azimuth  = 0;
        width    = 25736;
        exponent = 4096;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function void set_reg(sgan_pkg::t_cfg_idx idx, bit [15:0] data);
        case (idx)
            sgan_pkg::CFG_AZIMUTH:  azimuth  = data[14:0];
            sgan_pkg::CFG_WIDTH:    width    = data;
            sgan_pkg::CFG_EXPONENT: exponent = data[14:0];
            default: ;
        endcase
    endfunction

    function bit [15:0] raw_gain(logic signed [15:0] angle);
        int              d;
        int              mag;
        int              w;
        int              xp;
        int              k;
        longint unsigned u;
        longint unsigned y;
        longint unsigned frac;
        longint unsigned lg;
        longint unsigned e;
        longint unsigned p;
        longint unsigned p15;
        w  = (width == 0) ? 1 : width;
        xp = (exponent == 0) ? 1 : exponent;
        d  = int'(angle) - azimuth;
        while (d < -12868) d += 25736;
        while (d > 12868) d -= 25736;
        mag = (d < 0) ? -d : d;
        if (mag == 0) return 16'h8000;
        if (mag * 2 >= w) return 16'd0;
        u = (longint'(mag) << 17) / w;
        // normalize into [1, 2) then squaring log
        y = u;
        k = 0;
        frac = 0;
        while (y < 65536) begin
            y = y << 1;
            k++;
        end
        for (int i = 1; i <= 16; i++) begin
            y = (y * y) >> 16;
            if (y >= 131072) begin
                y = y >> 1;
                frac |= 64'd1 << (16 - i);
            end
        end
        lg = (longint'(k) << 16) - frac;
        e  = (lg * (2 * xp)) >> 12;
        p  = 64'd1 << 30;
        for (int i = 1; i <= 16; i++) begin
            if ((e >> (16 - i)) & 1) p = (p * roots[i]) >> 30;
        end
        if ((e >> 16) >= 31) p = 0;
        else p = p >> (e >> 16);
        p15 = (p + (64'd1 << 14)) >> 15;
        if (p15 >= 32768) return 16'd0;
        return 16'(32768 - p15);
    endfunction

    function void note_speaker(logic signed [15:0] angle, bit last);
        bit [15:0]       g;
        longint unsigned root;
        longint unsigned v;
        gain_exp_t       item;
        accepted++;
        if (count < 32) begin
            g = raw_gain(angle);
            store[count] = g;
            sq_sum += longint'(g) * g;
            count++;
        end
        if (!last) return;
        root = (sq_sum != 0) ? isqrt(sq_sum << 20) : 0;
        for (int i = 0; i < count; i++) begin
            v = store[i];
            if (root != 0) begin
                v = ((v << 25) + (root >> 1)) / root;
                if (v > 32768) v = 32768;
            end
            item.gain = v[15:0];
            item.last = (i + 1 == count);
            pending.push_back(item);
        end
        sq_sum = 0;
        count  = 0;
    endfunction

    function void check_gain(bit [15:0] gain, bit last);
        gain_exp_t want;
        checked++;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected gain %0d last %0d", gain, last);
            return;
        end
        want = pending.pop_front();
        if (want.gain !== gain || want.last !== last) begin
            errors++;
            if (errors <= 10)
                $display("gain #%0d: expected %0d/%0d, got %0d/%0d",
                         checked, want.gain, want.last, gain, last);
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sgan_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_speaker_angle = '0;
    logic               i_last_speaker = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [15:0]        o_gain;
    logic               o_last_gain;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;

    gain_scoreboard sb = new();
    bit             calm = 1'b0;
    int             hold_left = 0;
    int             runs = 0;

    speaker_gain_array_normalized_core dut (.*);

    always #5 i_clk = ~i_clk;

    // receiver: random stalls, one long hold-off at the 30th gain
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_gain(o_gain, o_last_gain);
            if (sb.checked == 30) hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_speaker(logic signed [15:0] angle, bit last);
        while (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_speaker_angle <= angle;
        i_last_speaker  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_speaker(angle, last);
        if (last) runs++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(t_cfg_idx idx, bit [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic setup(bit [15:0] az, bit [15:0] w, bit [15:0] xp);
        write_reg(CFG_AZIMUTH, az);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_EXPONENT, xp);
        i_cfg_we <= 1'b0;
    endtask

    // random layout: mostly near the source, some centered, some anywhere
    task automatic random_run(int n);
        logic signed [15:0] a;
        int                 w;
        int                 pick;
        w = (sb.width < 2) ? 2 : sb.width;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 15) a = 16'(sb.azimuth);
            else if (pick < 65) a = 16'(sb.azimuth + $urandom_range(w) - w / 2);
            else a = 16'($urandom);
            send_speaker(a, k == n - 1);
        end
    endtask

    task automatic random_phase(int items);
        int target;
        int n;
        target = sb.accepted + items;
        while (sb.accepted < target) begin
            n = $urandom_range(99);
            if (n < 88) n = $urandom_range(1, 12);
            else if (n < 96) n = $urandom_range(13, 32);
            else n = $urandom_range(33, 36);
            random_run(n);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: extremes of the angle, center, the pi boundary
        send_speaker(16'sd0, 1'b0);
        send_speaker(16'sd32767, 1'b0);
        send_speaker(-16'sd32768, 1'b0);
        send_speaker(16'sd12868, 1'b0);
        send_speaker(-16'sd12869, 1'b0);
        send_speaker(16'sd6000, 1'b0);
        send_speaker(-16'sd3000, 1'b1);
        send_speaker(16'sd100, 1'b1);
        random_phase(50);
        drain();

        // narrowest width, smallest exponent: everything off-center is silent
        setup(16'd0, 16'd1, 16'd1);
        send_speaker(16'sd5, 1'b0);
        send_speaker(-16'sd5, 1'b0);
        send_speaker(16'sd20000, 1'b1);
        send_speaker(16'sd0, 1'b1);
        random_phase(40);
        drain();

        // widest source, steepest curve, azimuth at 2pi; no idling here
        calm = 1'b1;
        setup(16'd25736, 16'd65535, 16'd32767);
        random_run(35);
        random_phase(50);
        drain();
        calm = 1'b0;

        // zero width and zero exponent fall back to one
        setup(16'd12868, 16'd0, 16'd0);
        send_speaker(16'sd12868, 1'b0);
        send_speaker(16'sd12869, 1'b1);
        random_phase(30);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            setup(16'($urandom_range(32767)), 16'($urandom_range(1, 65535)),
                  16'($urandom_range(1, 32767)));
            random_phase(30);
            drain();
        end

        $display("covered %0d speakers in %0d layouts across 8 register settings,",
                 sb.accepted, runs);
        $display("with %0d gains checked and %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/sgan_pkg.sv
hw/rtl/sgan_front.sv
hw/rtl/sgan_fifo.sv
hw/rtl/sgan_back.sv
hw/rtl/speaker_gain_array_normalized_core.sv
verif/speaker_gain_array_normalized_tb.sv
